>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Types and constants shared by the FAT chain allocator modules.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int THR_W        = 33;
  localparam int FIRST_USABLE = 3;

  localparam logic [15:0] ENTRY_FREE = 16'h0000;
  localparam logic [15:0] ENTRY_END  = 16'hFFFF;
  localparam logic [15:0] ENTRY_RSVD = 16'hFFFC;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_EXTEND = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_CHECK  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_LOOP   = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  head_block;
    logic [21:0] byte_size;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  new_block_index;
    logic [10:0] chain_length;
    logic        needs_more;
    logic [10:0] free_left;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       walk_init;
    logic       walk_en;
    logic       srch_init;
    logic       srch_en;
    logic       rd_head;
    logic       wr_link;
    logic       wr_end;
    logic       wr_free;
    logic       set_len;
    logic       set_st;
    logic [1:0] st_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] op;
    logic       head_bad;
    logic       free_bad;
    logic       walk_end;
    logic       walk_bad;
    logic       walk_loop;
    logic       srch_hit;
    logic       srch_none;
    logic       blk_used;
    logic       out_busy;
  } sts_t;

endpackage

>>> src/fca_ram.sv
// ----------------------------------------------------------------------------
// fca_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/fca_dp.sv
// ----------------------------------------------------------------------------
// fca_dp
// Datapath: table memory, chain walker, free search, count and result words.
// ----------------------------------------------------------------------------
module fca_dp #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fca_pkg::in_word_t in_word_i,
  input  logic              out_stall_i,
  input  fca_pkg::cmd_t     cmd_i,
  output fca_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  output fca_pkg::out_word_t out_word_o
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  fca_pkg::in_word_t  in_q;
  fca_pkg::out_word_t out_q;
  logic [IW-1:0]      cur_q, paddr_q, blk_q, new_blk_q, clr_q;
  logic [CW-1:0]      n_q, scan_q, len_q, free_q;
  logic [fca_pkg::THR_W-1:0] thr_q;
  logic               pend_q, more_q, out_valid_q;
  logic [1:0]         st_q;

  logic               we;
  logic [IW-1:0]      waddr, raddr, head_idx, link_idx;
  logic [15:0]        wdata, rdata, clr_val;
  logic               walk_adv;

  fca_ram #(
    .DW    (16),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign head_idx = IW'(in_q.head_block);
  assign link_idx = rdata[IW-1:0];

  always_comb begin
    if (clr_q < IW'(2)) begin
      clr_val = fca_pkg::ENTRY_RSVD;
    end else if (clr_q == IW'(2)) begin
      clr_val = fca_pkg::ENTRY_END;
    end else begin
      clr_val = fca_pkg::ENTRY_FREE;
    end
  end

  always_comb begin
    sts_o.clr_done  = (clr_q == IW'(NUM_BLOCKS - 1));
    sts_o.op        = in_q.op;
    sts_o.head_bad  = (32'(in_q.head_block) >= NUM_BLOCKS);
    sts_o.free_bad  = (in_q.head_block < 10'(fca_pkg::FIRST_USABLE)) ||
                      (32'(in_q.head_block) >= NUM_BLOCKS);
    sts_o.walk_end  = (rdata == fca_pkg::ENTRY_END);
    sts_o.walk_bad  = !sts_o.walk_end && (32'(rdata) >= NUM_BLOCKS);
    sts_o.walk_loop = !sts_o.walk_end && !sts_o.walk_bad && (32'(n_q) >= NUM_BLOCKS);
    sts_o.srch_hit  = pend_q && (rdata == fca_pkg::ENTRY_FREE);
    sts_o.srch_none = !sts_o.srch_hit && (32'(scan_q) == NUM_BLOCKS);
    sts_o.blk_used  = (rdata != fca_pkg::ENTRY_FREE);
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign walk_adv = cmd_i.walk_en && !sts_o.walk_end && !sts_o.walk_bad && !sts_o.walk_loop;

  // read port select
  always_comb begin
    if (cmd_i.walk_init || cmd_i.rd_head) begin
      raddr = head_idx;
    end else if (cmd_i.walk_en) begin
      raddr = link_idx;
    end else begin
      raddr = scan_q[IW-1:0];
    end
  end

  // write port select
  always_comb begin
    we    = 1'b1;
    waddr = clr_q;
    wdata = clr_val;
    if (cmd_i.clr_en) begin
      waddr = clr_q;
      wdata = clr_val;
    end else if (cmd_i.wr_link) begin
      waddr = cur_q;
      wdata = 16'(paddr_q);
    end else if (cmd_i.wr_end) begin
      waddr = blk_q;
      wdata = fca_pkg::ENTRY_END;
    end else if (cmd_i.wr_free) begin
      waddr = head_idx;
      wdata = fca_pkg::ENTRY_FREE;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      pend_q      <= 1'b0;
      free_q      <= CW'(NUM_BLOCKS - 3);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + IW'(1);
      end
      if (cmd_i.srch_init) begin
        pend_q <= 1'b0;
      end else if (cmd_i.srch_en) begin
        pend_q <= (32'(scan_q) < NUM_BLOCKS);
      end
      if (cmd_i.wr_end && free_q != '0) begin
        free_q <= free_q - CW'(1);
      end else if (cmd_i.wr_free && 32'(free_q) < NUM_BLOCKS - 3) begin
        free_q <= free_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q      <= in_word_i;
      new_blk_q <= '0;
      len_q     <= '0;
      more_q    <= 1'b0;
      st_q      <= fca_pkg::ST_OK;
    end
    if (cmd_i.walk_init) begin
      cur_q <= head_idx;
      n_q   <= CW'(1);
      thr_q <= fca_pkg::THR_W'(2 * BLOCK_BYTES);
    end else if (walk_adv) begin
      cur_q <= link_idx;
      n_q   <= n_q + CW'(1);
      thr_q <= thr_q + fca_pkg::THR_W'(BLOCK_BYTES);
    end
    if (cmd_i.srch_init) begin
      scan_q <= CW'(fca_pkg::FIRST_USABLE);
    end else if (cmd_i.srch_en) begin
      scan_q  <= scan_q + CW'(1);
      paddr_q <= scan_q[IW-1:0];
    end
    if (cmd_i.srch_en && sts_o.srch_hit) begin
      blk_q <= paddr_q;
    end
    if (cmd_i.wr_end) begin
      new_blk_q <= blk_q;
    end
    if (cmd_i.set_len) begin
      len_q  <= n_q;
      more_q <= (fca_pkg::THR_W'(in_q.byte_size) >= thr_q);
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.out_load) begin
      out_q.new_block_index <= 10'(new_blk_q);
      out_q.chain_length    <= 11'(len_q);
      out_q.needs_more      <= more_q;
      out_q.free_left       <= 11'(free_q);
      out_q.status          <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> src/fca_ctrl.sv
// ----------------------------------------------------------------------------
// fca_ctrl
// Controller: sequences clearing, chain walks, free search and table writes.
// ----------------------------------------------------------------------------
module fca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  fca_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output fca_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISP     = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_SRCH     = 3'd4;
  localparam logic [2:0] S_WR_END   = 3'd5;
  localparam logic [2:0] S_FREE_CHK = 3'd6;
  localparam logic [2:0] S_FIN      = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          fca_pkg::OP_ALLOC: begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_SRCH;
          end
          fca_pkg::OP_FREE: begin
            if (sts_i.free_bad) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = fca_pkg::ST_BAD;
              state_d       = S_FIN;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_FREE_CHK;
            end
          end
          default: begin
            if (sts_i.head_bad) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = fca_pkg::ST_BAD;
              state_d       = S_FIN;
            end else begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_end) begin
          if (sts_i.op == fca_pkg::OP_EXTEND) begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_SRCH;
          end else begin
            cmd_o.set_len = 1'b1;
            state_d       = S_FIN;
          end
        end else if (sts_i.walk_bad) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = fca_pkg::ST_BAD;
          state_d       = S_FIN;
        end else if (sts_i.walk_loop) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = fca_pkg::ST_LOOP;
          state_d       = S_FIN;
        end
      end
      S_SRCH: begin
        cmd_o.srch_en = 1'b1;
        if (sts_i.srch_hit) begin
          cmd_o.wr_link = (sts_i.op == fca_pkg::OP_EXTEND);
          state_d       = S_WR_END;
        end else if (sts_i.srch_none) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = fca_pkg::ST_NOFREE;
          state_d       = S_FIN;
        end
      end
      S_WR_END: begin
        cmd_o.wr_end = 1'b1;
        state_d      = S_FIN;
      end
      S_FREE_CHK: begin
        cmd_o.wr_free = sts_i.blk_used;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/fat_chain_allocator_core.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_core
// File allocation table with chain allocate, extend, free and size check.
//
//   channel   dir   handshake              word
//   in        in    in_valid_i/in_stall_o  fca_pkg::in_word_t
//   out       out   out_valid_o/out_stall_i fca_pkg::out_word_t
//
// After reset the table is cleared one entry per cycle while in_stall_o
// stays high. The free search and the chain walk read one table entry
// per cycle.
// A finished word waits in the output register while the next word enters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat_chain_allocator_core #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fca_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fca_pkg::out_word_t out_word_o
);

  fca_pkg::cmd_t cmd;
  fca_pkg::sts_t sts;

  fca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  fca_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPL(a_free_bound, clk_i, rst_ni, out_valid_o, 32'(out_word_o.free_left) <= 32'(NUM_BLOCKS - 3) || NUM_BLOCKS > 2050)
  `ASSERT_IMPL(a_nofree_zero, clk_i, rst_ni, out_valid_o && out_word_o.status == fca_pkg::ST_NOFREE, out_word_o.new_block_index == 10'd0)
  `ASSERT_IMPL(a_more_ok, clk_i, rst_ni, out_valid_o && out_word_o.needs_more, out_word_o.status == fca_pkg::ST_OK)

endmodule

>>> tb/fat_chain_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_core_tb
// Self-checking bench for the FAT chain allocator. A local copy of the table
// and free count predicts every result word. Directed cases cover reset state,
// bad indexes and broken links. Random chain sequences and noise run with
// input idle gaps and bursty output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_chain_allocator_core_tb;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 2048;
  localparam int RAND_WORDS  = 550;
  localparam int CALM_WORDS  = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  fca_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  fca_pkg::out_word_t out_word_o;

  logic [15:0]        fat_tbl [NUM_BLOCKS];
  int unsigned        free_cnt;
  fca_pkg::out_word_t fat_result_q [$];
  fca_pkg::out_word_t want_word;
  int unsigned        chain_heads [$];
  int                 mismatches;
  bit                 quiet;

  fat_chain_allocator_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void fat_reset();
    for (int i = 0; i < NUM_BLOCKS; i++) fat_tbl[i] = fca_pkg::ENTRY_FREE;
    fat_tbl[0] = fca_pkg::ENTRY_RSVD;
    fat_tbl[1] = fca_pkg::ENTRY_RSVD;
    fat_tbl[2] = fca_pkg::ENTRY_END;
    free_cnt = NUM_BLOCKS - 3;
  endfunction

  function automatic bit lowest_free_block(output int unsigned blk);
    blk = 0;
    for (int i = fca_pkg::FIRST_USABLE; i < NUM_BLOCKS; i++) begin
      if (fat_tbl[i] == fca_pkg::ENTRY_FREE) begin
        blk = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] walk_chain(input int unsigned head,
                                            output int unsigned tail,
                                            output int unsigned len);
    int unsigned cur;
    int unsigned n;
    int unsigned link;
    cur = head;
    n = 1;
    tail = 0;
    len = 0;
    if (cur >= NUM_BLOCKS) return fca_pkg::ST_BAD;
    while (fat_tbl[cur] != fca_pkg::ENTRY_END) begin
      link = fat_tbl[cur];
      if (link >= NUM_BLOCKS) return fca_pkg::ST_BAD;
      if (n >= NUM_BLOCKS) return fca_pkg::ST_LOOP;
      cur = link;
      n++;
    end
    tail = cur;
    len = n;
    return fca_pkg::ST_OK;
  endfunction

  function automatic fca_pkg::out_word_t fat_apply_op(input fca_pkg::in_word_t w);
    fca_pkg::out_word_t r;
    int unsigned        tail;
    int unsigned        len;
    int unsigned        blk;
    logic [1:0]         st;
    r = '0;
    case (w.op)
      fca_pkg::OP_ALLOC: begin
        if (lowest_free_block(blk)) begin
          fat_tbl[blk] = fca_pkg::ENTRY_END;
          if (free_cnt > 0) free_cnt--;
          r.new_block_index = 10'(blk);
        end else begin
          r.status = fca_pkg::ST_NOFREE;
        end
      end
      fca_pkg::OP_EXTEND: begin
        st = walk_chain(w.head_block, tail, len);
        if (st == fca_pkg::ST_OK) begin
          if (lowest_free_block(blk)) begin
            fat_tbl[tail] = 16'(blk);
            fat_tbl[blk] = fca_pkg::ENTRY_END;
            if (free_cnt > 0) free_cnt--;
            r.new_block_index = 10'(blk);
          end else begin
            st = fca_pkg::ST_NOFREE;
          end
        end
        r.status = st;
      end
      fca_pkg::OP_FREE: begin
        if (w.head_block < fca_pkg::FIRST_USABLE || w.head_block >= NUM_BLOCKS) begin
          r.status = fca_pkg::ST_BAD;
        end else if (fat_tbl[w.head_block] != fca_pkg::ENTRY_FREE) begin
          fat_tbl[w.head_block] = fca_pkg::ENTRY_FREE;
          if (free_cnt < NUM_BLOCKS - 3) free_cnt++;
        end
      end
      default: begin
        st = walk_chain(w.head_block, tail, len);
        r.status = st;
        if (st == fca_pkg::ST_OK) begin
          r.chain_length = 11'(len);
          r.needs_more = (w.byte_size / BLOCK_BYTES) > len;
        end
      end
    endcase
    r.free_left = 11'(free_cnt);
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input int unsigned head,
                           input int unsigned size, output fca_pkg::out_word_t r);
    fca_pkg::in_word_t w;
    w.op = op;
    w.head_block = 10'(head);
    w.byte_size = 22'(size);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
    r = fat_apply_op(w);
    fat_result_q = {fat_result_q, r};
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fat_result_q.size() == 0) begin
        $display("%0t: word expected none got %h", $time, out_word_o);
        mismatches++;
      end else begin
        want_word = fat_result_q.pop_front();
        check_field("new_block_index", want_word.new_block_index,
                    out_word_o.new_block_index);
        check_field("chain_length", want_word.chain_length, out_word_o.chain_length);
        check_field("needs_more", want_word.needs_more, out_word_o.needs_more);
        check_field("free_left", want_word.free_left, out_word_o.free_left);
        check_field("status", want_word.status, out_word_o.status);
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      if (quiet) begin
        @(negedge clk_i) out_stall_i = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 11)) @(negedge clk_i) out_stall_i = 1'b1;
      end else begin
        repeat ($urandom_range(1, 30)) @(negedge clk_i) out_stall_i = 1'b0;
      end
    end
  end

  task automatic test_directed();
    fca_pkg::out_word_t r;
    send_word(fca_pkg::OP_CHECK, 2, 0, r);
    send_word(fca_pkg::OP_CHECK, 2, 4095, r);
    send_word(fca_pkg::OP_CHECK, 2, 4096, r);
    send_word(fca_pkg::OP_CHECK, 0, 22'h3FFFFF, r);
    send_word(fca_pkg::OP_CHECK, 1, 0, r);
    send_word(fca_pkg::OP_CHECK, 1023, 22'h155555, r);
    send_word(fca_pkg::OP_EXTEND, 5, 0, r);
    send_word(fca_pkg::OP_ALLOC, 1023, 22'h3FFFFF, r);
    send_word(fca_pkg::OP_ALLOC, 0, 0, r);
    send_word(fca_pkg::OP_EXTEND, 2, 0, r);
    send_word(fca_pkg::OP_EXTEND, 2, 22'h2AAAAA, r);
    send_word(fca_pkg::OP_EXTEND, 3, 0, r);
    send_word(fca_pkg::OP_CHECK, 2, 22'h3FFFFF, r);
    send_word(fca_pkg::OP_CHECK, 2, 6144, r);
    send_word(fca_pkg::OP_FREE, 0, 0, r);
    send_word(fca_pkg::OP_FREE, 1, 0, r);
    send_word(fca_pkg::OP_FREE, 2, 0, r);
    send_word(fca_pkg::OP_FREE, 1023, 0, r);
    send_word(fca_pkg::OP_FREE, 5, 0, r);
    send_word(fca_pkg::OP_CHECK, 2, 0, r);
    send_word(fca_pkg::OP_EXTEND, 2, 0, r);
    send_word(fca_pkg::OP_ALLOC, 512, 0, r);
    send_word(fca_pkg::OP_FREE, 3, 0, r);
  endtask

  task automatic chain_sequence(inout int sent);
    fca_pkg::out_word_t r;
    int unsigned        head;
    int unsigned        tail;
    int unsigned        len;
    int unsigned        blk;
    int unsigned        blocks [$];
    repeat ($urandom_range(0, 3)) begin
      send_word(fca_pkg::OP_FREE, $urandom_range(3, 1023), $urandom, r);
      sent++;
    end
    send_word(fca_pkg::OP_ALLOC, $urandom_range(0, 1023), $urandom, r);
    sent++;
    if (r.status == fca_pkg::ST_OK) begin
      head = r.new_block_index;
      chain_heads = {chain_heads, head};
      if (chain_heads.size() > 64) void'(chain_heads.pop_front());
    end else begin
      head = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
    end
    repeat ($urandom_range(0, 10)) begin
      send_word(fca_pkg::OP_EXTEND, head, $urandom, r);
      sent++;
    end
    void'(walk_chain(head, tail, len));
    send_word(fca_pkg::OP_CHECK, head,
              (len + $urandom_range(0, 1)) * BLOCK_BYTES + $urandom_range(0, 2047), r);
    sent++;
    if ($urandom_range(0, 1) == 1) begin
      blk = head;
      while (blocks.size() < NUM_BLOCKS && blk >= fca_pkg::FIRST_USABLE &&
             blk < NUM_BLOCKS && fat_tbl[blk] != fca_pkg::ENTRY_FREE) begin
        blocks = {blocks, blk};
        if (fat_tbl[blk] == fca_pkg::ENTRY_END) break;
        blk = fat_tbl[blk];
      end
      if ($urandom_range(0, 1) == 1 && blocks.size() > 1) begin
        send_word(fca_pkg::OP_FREE, blocks[blocks.size() - 1], 0, r);
        sent++;
      end
      foreach (blocks[i]) send_word(fca_pkg::OP_FREE, blocks[i], $urandom, r);
      sent += blocks.size();
      send_word(fca_pkg::OP_CHECK, head, $urandom, r);
      sent++;
    end
  endtask

  task automatic test_random();
    fca_pkg::out_word_t r;
    int                 sent;
    sent = 0;
    while (sent < RAND_WORDS) begin
      quiet = (sent >= RAND_WORDS - CALM_WORDS);
      if ($urandom_range(0, 9) < 6) begin
        chain_sequence(sent);
      end else begin
        if ($urandom_range(0, 2) == 0)
          send_word(2'($urandom), chain_heads[$urandom_range(0, chain_heads.size() - 1)],
                    $urandom, r);
        else
          send_word(2'($urandom), $urandom_range(0, 1023), $urandom, r);
        sent++;
      end
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_word_i = '0;
    quiet = 1'b0;
    mismatches = 0;
    chain_heads = {chain_heads, 32'd2};
    fat_reset();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed();
    test_random();
    in_valid_i = 1'b0;
    while (fat_result_q.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_BLOCKS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
